[design/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define TCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tcw_pkg.sv]
package tcw_pkg;

   localparam int TCW_MAX_COLS = 128;
   localparam int TCW_MAX_ROWS = 64;

   localparam int GLYPH_W  = 21;
   localparam int PAD_BIT  = 21;
   localparam int ATTR_BIT = 22;
   localparam int CELL_W   = 23;

   localparam logic [GLYPH_W-1:0] SPACE_CP    = 21'd32;
   localparam logic [GLYPH_W-1:0] NEWLINE_CP  = 21'd10;
   localparam logic [GLYPH_W-1:0] ASCII_LIMIT = 21'd128;
   localparam logic [6:0]         SPACE_TEXT  = 7'd32;

   // cell word: {reverse, pad, glyph}
   localparam logic [CELL_W-1:0] BLANK_CELL = {1'b0, 1'b0, SPACE_CP};
   localparam logic [CELL_W-1:0] PAD_CELL   = {1'b0, 1'b1, 21'd0};
   localparam logic [CELL_W-1:0] MARK_CELL  = {1'b1, 1'b0, SPACE_CP};

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_PUT   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [6:0] HEIGHT_RESET = 7'd25;

   typedef struct packed {
      logic [1:0]  operation;
      logic [20:0] codepoint;
      logic [1:0]  column_width;
      logic [5:0]  read_row;
      logic [6:0]  read_col;
   } tcw_req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [5:0]  cursor_row;
      logic [5:0]  top_row;
      logic [20:0] cell_glyph;
      logic        cell_is_pad;
      logic [6:0]  cell_text;
      logic        cell_reverse;
   } tcw_rsp_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } tcw_stat_type;

endpackage

[design/text_console_writer.sv]
// Character-cell console writer. Each word on req_ carries one operation (begin message,
// put codepoint, read cell) and yields exactly one word on rsp_ with the cursor, the top of
// the scroll region and, for reads, the cell contents. The cell grid lives in a single-port
// RAM of MAX_COLS*MAX_ROWS words, and that one port sets the pace: a begin message or an
// unused operation only dispatches and responds, a read makes one RAM read, an ordinary
// put writes the glyph, a pad cell for a wide glyph and the cursor mark. A newline blanks
// the rest of the line before the mark, and a put that fills the last column also moves to
// the next line; past the last row the scroll reads and rewrites each copied cell over the
// region and then blanks the new bottom row. After reset all MAX_COLS*MAX_ROWS RAM words
// (8192 at the default size) are swept to blanks with req_stall held high; csr_ writes are
// taken at any time but must only be issued while the block is idle.
// The result sits in an output register, so the next word is taken while it waits.
`include "assert_macros.svh"

module text_console_writer #(
   parameter int MAX_COLS = tcw_pkg::TCW_MAX_COLS,
   parameter int MAX_ROWS = tcw_pkg::TCW_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tcw_pkg::tcw_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tcw_pkg::tcw_rsp_type rsp_data,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata
);

   import tcw_pkg::*;

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);

   logic [7:0]   width_ff, width_in;
   logic [6:0]   height_ff, height_in;
   logic [CW:0]  eff_cols;
   logic [RW:0]  eff_rows;

   logic         rsp_valid_ff, rsp_valid_in;
   tcw_rsp_type  rsp_data_ff, rsp_data_in;
   logic         res_ready;

   tcw_stat_type seq_stat;
   tcw_rsp_type  seq_res;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata[6:0];
            default:           width_in  = width_ff;
         endcase
      end
   end

   // clamp the screen size into 1..MAX
   always_comb begin
      priority if (width_ff == '0) begin
         eff_cols = (CW+1)'(1);
      end else if (32'(width_ff) > MAX_COLS) begin
         eff_cols = (CW+1)'(MAX_COLS);
      end else begin
         eff_cols = (CW+1)'(width_ff);
      end
      priority if (height_ff == '0) begin
         eff_rows = (RW+1)'(1);
      end else if (32'(height_ff) > MAX_ROWS) begin
         eff_rows = (RW+1)'(MAX_ROWS);
      end else begin
         eff_rows = (RW+1)'(height_ff);
      end
   end

   // take a new result whenever the output register is empty or draining
   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_ready ? seq_stat.res_valid : rsp_valid_ff;
   assign rsp_data_in  = res_ready ? seq_res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   tcw_seq #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .eff_cols   (eff_cols),
      .eff_rows   (eff_rows),
      .item_valid (req_valid),
      .item       (req_data),
      .res_ready  (res_ready),
      .stat       (seq_stat),
      .res        (seq_res)
   );

   assign req_stall = !seq_stat.idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TCW_ASSERT(a_result_lands, clock, reset,
               ((seq_stat.res_valid && res_ready) |=> rsp_valid_ff),
               "result left the sequencer but did not reach the output register")

endmodule

[design/tcw_ram.sv]
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/tcw_seq.sv]
`include "assert_macros.svh"

module tcw_seq #(
   parameter int MAX_COLS = tcw_pkg::TCW_MAX_COLS,
   parameter int MAX_ROWS = tcw_pkg::TCW_MAX_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [$clog2(MAX_COLS):0]   eff_cols,
   input  logic [$clog2(MAX_ROWS):0]   eff_rows,
   input  logic                        item_valid,
   input  tcw_pkg::tcw_req_type        item,
   input  logic                        res_ready,
   output tcw_pkg::tcw_stat_type       stat,
   output tcw_pkg::tcw_rsp_type        res
);

   import tcw_pkg::*;

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_GLYPH,
      S_PAD,
      S_BLANK,
      S_SCROLL_RD,
      S_SCROLL_WR,
      S_LAST,
      S_MARK,
      S_RESP
   } state_type;

   state_type       state_ff, state_in;
   tcw_req_type     item_ff, item_in;
   logic [CW:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]   cur_row_ff, cur_row_in;
   logic [RW-1:0]   top_ff, top_in;
   logic [RW-1:0]   walk_row_ff, walk_row_in;
   logic [CW-1:0]   walk_col_ff, walk_col_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [20:0]     glyph_ff, glyph_in;
   logic            pad_ff, pad_in;
   logic [6:0]      text_ff, text_in;
   logic            rev_ff, rev_in;

   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_addr;
   logic [CELL_W-1:0] mem_wdata;
   logic [CELL_W-1:0] mem_rdata;

   logic [CW:0]   col_inc;
   logic [CW-1:0] col_lo;
   logic [RW-1:0] last_row;
   logic [RW-1:0] top_dec;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
      return AW'(row) * AW'(MAX_COLS) + AW'(col);
   endfunction

   assign col_inc  = cur_col_ff + (CW+1)'(1);
   assign col_lo   = cur_col_ff[CW-1:0];
   assign last_row = RW'(eff_rows - (RW+1)'(1));
   assign top_dec  = (top_ff == '0) ? top_ff : top_ff - RW'(1);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      top_in      = top_ff;
      walk_row_in = walk_row_ff;
      walk_col_in = walk_col_ff;
      clr_addr_in = clr_addr_ff;
      glyph_in    = glyph_ff;
      pad_in      = pad_ff;
      text_in     = text_ff;
      rev_in      = rev_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = '0;
      mem_wdata   = BLANK_CELL;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            glyph_in = '0;
            pad_in   = 1'b0;
            text_in  = '0;
            rev_in   = 1'b0;
            state_in = S_RESP;
            priority if (item_ff.operation == OP_BEGIN) begin
               cur_row_in = last_row;
               top_in     = last_row;
               cur_col_in = '0;
            end else if (item_ff.operation == OP_PUT) begin
               if (item_ff.codepoint != '0) begin
                  // pull the cursor back inside a shrunk screen
                  if (cur_col_ff >= eff_cols) begin
                     cur_col_in = eff_cols - (CW+1)'(1);
                  end
                  if ({1'b0, cur_row_ff} >= eff_rows) begin
                     cur_row_in = last_row;
                  end
                  if ({1'b0, top_ff} >= eff_rows) begin
                     top_in = last_row;
                  end
                  priority if (item_ff.codepoint == NEWLINE_CP) begin
                     state_in = S_BLANK;
                  end else if (item_ff.column_width != '0) begin
                     state_in = S_GLYPH;
                  end else begin
                     state_in = S_MARK;
                  end
               end
            end else if (item_ff.operation == OP_READ) begin
               if (32'(item_ff.read_row) < MAX_ROWS && 32'(item_ff.read_col) < MAX_COLS) begin
                  mem_re   = 1'b1;
                  mem_addr = cell_addr(RW'(item_ff.read_row), CW'(item_ff.read_col));
                  state_in = S_READ;
               end else begin
                  glyph_in = SPACE_CP;
                  text_in  = SPACE_TEXT;
               end
            end else begin
               state_in = S_RESP;
            end
         end

         S_READ: begin
            rev_in = mem_rdata[ATTR_BIT];
            if (mem_rdata[PAD_BIT]) begin
               pad_in   = 1'b1;
               glyph_in = '0;
               text_in  = SPACE_TEXT;
            end else begin
               pad_in   = 1'b0;
               glyph_in = mem_rdata[GLYPH_W-1:0];
               text_in  = (mem_rdata[GLYPH_W-1:0] < ASCII_LIMIT) ? mem_rdata[6:0]
                                                                : SPACE_TEXT;
            end
            state_in = S_RESP;
         end

         S_GLYPH: begin
            mem_we     = 1'b1;
            mem_addr   = cell_addr(cur_row_ff, col_lo);
            mem_wdata  = {1'b0, 1'b0, item_ff.codepoint};
            cur_col_in = col_inc;
            priority if (item_ff.column_width[1] && col_inc < eff_cols) begin
               state_in = S_PAD;
            end else if (col_inc == eff_cols) begin
               state_in = S_BLANK;
            end else begin
               state_in = S_MARK;
            end
         end

         S_PAD: begin
            mem_we     = 1'b1;
            mem_addr   = cell_addr(cur_row_ff, col_lo);
            mem_wdata  = PAD_CELL;
            cur_col_in = col_inc;
            state_in   = (col_inc == eff_cols) ? S_BLANK : S_MARK;
         end

         S_BLANK: begin
            if (cur_col_ff < eff_cols) begin
               // blank the rest of the line, one cell a cycle
               mem_we     = 1'b1;
               mem_addr   = cell_addr(cur_row_ff, col_lo);
               mem_wdata  = BLANK_CELL;
               cur_col_in = col_inc;
            end else begin
               cur_col_in = '0;
               top_in     = top_dec;
               if ({1'b0, cur_row_ff} + (RW+1)'(1) >= eff_rows) begin
                  cur_row_in  = last_row;
                  walk_row_in = top_dec;
                  walk_col_in = '0;
                  state_in    = ({1'b0, top_dec} + (RW+1)'(1) < eff_rows) ? S_SCROLL_RD
                                                                        : S_LAST;
               end else begin
                  cur_row_in = cur_row_ff + RW'(1);
                  state_in   = S_MARK;
               end
            end
         end

         S_SCROLL_RD: begin
            mem_re   = 1'b1;
            mem_addr = cell_addr(walk_row_ff + RW'(1), walk_col_ff);
            state_in = S_SCROLL_WR;
         end

         S_SCROLL_WR: begin
            mem_we    = 1'b1;
            mem_addr  = cell_addr(walk_row_ff, walk_col_ff);
            mem_wdata = mem_rdata;
            if ({1'b0, walk_col_ff} + (CW+1)'(1) < eff_cols) begin
               walk_col_in = walk_col_ff + CW'(1);
               state_in    = S_SCROLL_RD;
            end else begin
               walk_col_in = '0;
               if ({2'b00, walk_row_ff} + (RW+2)'(2) < {1'b0, eff_rows}) begin
                  walk_row_in = walk_row_ff + RW'(1);
                  state_in    = S_SCROLL_RD;
               end else begin
                  state_in = S_LAST;
               end
            end
         end

         S_LAST: begin
            mem_we    = 1'b1;
            mem_addr  = cell_addr(last_row, walk_col_ff);
            mem_wdata = BLANK_CELL;
            if ({1'b0, walk_col_ff} + (CW+1)'(1) < eff_cols) begin
               walk_col_in = walk_col_ff + CW'(1);
            end else begin
               state_in = S_MARK;
            end
         end

         S_MARK: begin
            mem_we    = 1'b1;
            mem_addr  = cell_addr(cur_row_ff, col_lo);
            mem_wdata = MARK_CELL;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         top_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         top_ff      <= top_in;
      end
      item_ff     <= item_in;
      walk_row_ff <= walk_row_in;
      walk_col_ff <= walk_col_in;
      glyph_ff    <= glyph_in;
      pad_ff      <= pad_in;
      text_ff     <= text_in;
      rev_ff      <= rev_in;
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign stat.idle      = (state_ff == S_IDLE);
   assign stat.res_valid = (state_ff == S_RESP);

   assign res.cursor_col   = 7'(cur_col_ff);
   assign res.cursor_row   = 6'(cur_row_ff);
   assign res.top_row      = 6'(top_ff);
   assign res.cell_glyph   = glyph_ff;
   assign res.cell_is_pad  = pad_ff;
   assign res.cell_text    = text_ff;
   assign res.cell_reverse = rev_ff;

   `TCW_ASSERT_ALWAYS(a_port_one_op, clock, !(mem_we && mem_re),
                      "cell memory read and written in the same cycle")
   `TCW_ASSERT(a_read_issued, clock, reset,
               ((state_ff == S_READ || state_ff == S_SCROLL_WR) |-> $past(mem_re)),
               "cell data used without a read issued the cycle before")

endmodule

[tb/sv/tcw_console_checker.sv]
module tcw_console_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  tcw_pkg::tcw_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tcw_pkg::tcw_rsp_type rsp_data,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata,
   output int                   mismatches,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int COLS  = TCW_MAX_COLS;
   localparam int ROWS  = TCW_MAX_ROWS;
   localparam int CELLS = COLS * ROWS;

   localparam logic [21:0] BLANK_GLYPH = {1'b0, SPACE_CP};
   localparam logic [21:0] PAD_GLYPH   = {1'b1, 21'd0};

   // bit 21 of a glyph entry flags the right half of a wide glyph
   logic [21:0] glyph_mem [CELLS];
   logic        rev_mem   [CELLS];
   int          caret_col, caret_row, scroll_top;
   int          cols_reg, rows_reg;

   tcw_rsp_type predicted_rsp [$];

   function automatic int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > COLS) return COLS;
      return cols_reg;
   endfunction

   function automatic int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > ROWS) return ROWS;
      return rows_reg;
   endfunction

   function automatic void paint(int row, int col, logic [21:0] g, logic rev);
      int idx;
      idx = row * COLS + col;
      if (idx < CELLS) begin
         glyph_mem[idx] = g;
         rev_mem[idx]   = rev;
      end
   endfunction

   function automatic void line_feed(int w, int h);
      int r, c;
      for (c = caret_col; c < w; c++) paint(caret_row, c, BLANK_GLYPH, 1'b0);
      if (scroll_top > 0) scroll_top--;
      caret_row++;
      caret_col = 0;
      if (caret_row >= h) begin
         // shift the region up one row, then blank the bottom row
         for (r = scroll_top; r + 1 < h; r++) begin
            for (c = 0; c < w; c++) begin
               glyph_mem[r * COLS + c] = glyph_mem[(r + 1) * COLS + c];
               rev_mem[r * COLS + c]   = rev_mem[(r + 1) * COLS + c];
            end
         end
         for (c = 0; c < w; c++) paint(h - 1, c, BLANK_GLYPH, 1'b0);
         caret_row = h - 1;
      end
   endfunction

   function automatic tcw_rsp_type console_step(tcw_req_type wd);
      tcw_rsp_type r;
      int          w, h, idx;
      logic [21:0] v;
      r = '0;
      w = eff_cols();
      h = eff_rows();
      case (wd.operation)
         OP_BEGIN: begin
            caret_row  = h - 1;
            scroll_top = caret_row;
            caret_col  = 0;
         end
         OP_PUT: begin
            if (wd.codepoint != '0) begin
               // the screen may have shrunk under the cursor
               if (caret_col >= w) caret_col = w - 1;
               if (caret_row >= h) caret_row = h - 1;
               if (scroll_top >= h) scroll_top = h - 1;
               if (wd.codepoint == NEWLINE_CP) begin
                  line_feed(w, h);
               end else if (wd.column_width != 2'd0) begin
                  paint(caret_row, caret_col, {1'b0, wd.codepoint}, 1'b0);
                  caret_col++;
                  if (wd.column_width >= 2'd2 && caret_col < w) begin
                     paint(caret_row, caret_col, PAD_GLYPH, 1'b0);
                     caret_col++;
                  end
                  if (caret_col == w) line_feed(w, h);
               end
               paint(caret_row, caret_col, BLANK_GLYPH, 1'b1);
            end
         end
         OP_READ: begin
            if (wd.read_row < ROWS && wd.read_col < COLS) begin
               idx            = wd.read_row * COLS + wd.read_col;
               v              = glyph_mem[idx];
               r.cell_reverse = rev_mem[idx];
               if (v[PAD_BIT]) begin
                  r.cell_is_pad = 1'b1;
                  r.cell_glyph  = '0;
                  r.cell_text   = SPACE_TEXT;
               end else begin
                  r.cell_glyph = v[GLYPH_W-1:0];
                  r.cell_text  = (r.cell_glyph < ASCII_LIMIT) ? r.cell_glyph[6:0] : SPACE_TEXT;
               end
            end else begin
               r.cell_glyph = SPACE_CP;
               r.cell_text  = SPACE_TEXT;
            end
         end
         default: ;
      endcase
      r.cursor_col = 7'(caret_col);
      r.cursor_row = 6'(caret_row);
      r.top_row    = 6'(scroll_top);
      return r;
   endfunction

   always @(posedge clock) begin
      tcw_rsp_type want;
      int          i;
      if (reset) begin
         for (i = 0; i < CELLS; i++) begin
            glyph_mem[i] = BLANK_GLYPH;
            rev_mem[i]   = 1'b0;
         end
         caret_col  = 0;
         caret_row  = 0;
         scroll_top = 0;
         cols_reg   = WIDTH_RESET;
         rows_reg   = HEIGHT_RESET;
         mismatches = 0;
         predicted_rsp.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_SCREEN_WIDTH) cols_reg = csr_wdata;
            else rows_reg = csr_wdata[6:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t: rsp word with nothing expected: %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: rsp mismatch, expected %p, actual %p",
                           $time, want, rsp_data);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) predicted_rsp.push_back(console_step(req_data));
      end
      pending = predicted_rsp.size();
   end

endmodule

[tb/sv/tb_text_console_writer.sv]
module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam logic [1:0] OP_SPARE    = 2'd3;
   localparam int         HOLD_CYCLES = 300;
   localparam int         SETTLE      = 16;
   localparam int         PHASES      = 11;
   localparam longint     TIMEOUT_NS  = 100_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   tcw_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   tcw_rsp_type rsp_data;
   logic        csr_write;
   logic        csr_index;
   logic [7:0]  csr_wdata;
   int          mismatches;
   int          pending;

   bit calm     = 1'b0;
   bit hold_req = 1'b0;
   bit big      = 1'b0;
   int scr_cols = 80;
   int scr_rows = 25;

   // mostly small screens; the large ones run fewer words
   int phase_w [PHASES] = '{1, 0, 2, 3, 255, 5, 128, 16, 9, 80, 40};
   int phase_h [PHASES] = '{1, 0, 2, 4, 255, 3, 64, 8, 6, 25, 12};

   text_console_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tcw_console_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int k;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 25);
      end
   end

   // enter and leave at a falling edge
   task automatic send_word(input tcw_req_type wd);
      while (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= wd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input int cp, input int cw,
                          input int row, input int col);
      tcw_req_type wd;
      wd.operation    = op;
      wd.codepoint    = 21'(cp);
      wd.column_width = 2'(cw);
      wd.read_row     = 6'(row);
      wd.read_col     = 7'(col);
      send_word(wd);
   endtask

   // drop valid and let every outstanding word come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_screen(input logic [7:0] w, input logic [7:0] h);
      csr_write <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_write <= 1'b0;
      scr_cols = (w == 0) ? 1 : ((w > TCW_MAX_COLS) ? TCW_MAX_COLS : w);
      scr_rows = (h[6:0] == 0) ? 1 : ((h[6:0] > TCW_MAX_ROWS) ? TCW_MAX_ROWS : h[6:0]);
      big = (scr_cols * scr_rows > 256);
   endtask

   function automatic tcw_req_type random_word();
      tcw_req_type wd;
      int          pick;
      wd.operation    = 2'($urandom);
      wd.codepoint    = 21'($urandom);
      wd.column_width = 2'($urandom);
      wd.read_row     = 6'($urandom);
      wd.read_col     = 7'($urandom);
      pick = $urandom_range(99);
      if (pick < (big ? 8 : 4)) begin
         wd.operation = OP_BEGIN;
      end else if (pick < 30) begin
         wd.operation = OP_READ;
         if ($urandom_range(99) < 80) begin
            wd.read_row = 6'($urandom_range(scr_rows - 1));
            wd.read_col = 7'($urandom_range(scr_cols - 1));
         end
      end else if (pick < 32) begin
         wd.operation = OP_SPARE;
      end else begin
         wd.operation = OP_PUT;
         pick = $urandom_range(99);
         // keep newlines rare on large screens, where scrolls are slow
         if (pick < (big ? 4 : 12)) wd.codepoint = NEWLINE_CP;
         else if (pick < (big ? 8 : 16)) wd.codepoint = '0;
         else if (pick < 60) wd.codepoint = 21'($urandom_range(32, 126));
         else if (pick < 75) wd.codepoint = 21'($urandom_range(128, 21'h10FFFF));
         else if (pick < 85) wd.codepoint = 21'($urandom_range(1, 127));
         pick = $urandom_range(99);
         wd.column_width = (pick < 5) ? 2'd0 : (pick < 62) ? 2'd1 : (pick < 94) ? 2'd2 : 2'd3;
      end
      return wd;
   endfunction

   initial begin
      int p, i, n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = CSR_SCREEN_WIDTH;
      csr_wdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset screen size, cursor at top-left
      send_op(OP_READ, 0, 0, 0, 0);
      send_op(OP_SPARE, 21'h1FFFFF, 3, 63, 127);
      send_op(OP_PUT, 0, 1, 0, 0);
      send_op(OP_PUT, 65, 1, 0, 0);
      send_op(OP_PUT, 21'h10FFFF, 2, 0, 0);
      send_op(OP_PUT, 21'h1FFFFF, 3, 0, 0);
      send_op(OP_PUT, 120, 0, 0, 0);
      send_op(OP_READ, 0, 0, 0, 1);
      send_op(OP_READ, 0, 0, 0, 2);
      send_op(OP_READ, 0, 0, 0, 3);
      send_op(OP_READ, 0, 0, 0, 5);
      send_op(OP_PUT, NEWLINE_CP, 0, 0, 0);
      send_op(OP_READ, 0, 0, 0, 5);
      send_op(OP_READ, 0, 0, 63, 127);
      send_op(OP_BEGIN, 21'h1FFFFF, 3, 63, 127);
      send_op(OP_PUT, NEWLINE_CP, 1, 0, 0);
      drain();

      // shrink the screen under the cursor, then fill a line with a wide glyph last
      set_screen(8'd3, 8'd2);
      send_op(OP_PUT, 122, 1, 0, 0);
      send_op(OP_BEGIN, 0, 0, 0, 0);
      send_op(OP_PUT, 97, 1, 0, 0);
      send_op(OP_PUT, 98, 1, 0, 0);
      send_op(OP_PUT, 99, 2, 0, 0);
      send_op(OP_READ, 0, 0, 0, 2);
      send_op(OP_READ, 0, 0, 1, 0);
      send_op(OP_READ, 0, 0, 0, 0);
      send_op(OP_PUT, 100, 2, 0, 0);
      drain();

      for (p = 0; p < PHASES; p++) begin
         set_screen(8'(phase_w[p]), 8'(phase_h[p]));
         calm = (p == 3);
         n = big ? 100 : 190;
         if (big || $urandom_range(1) == 1) send_op(OP_BEGIN, 0, 0, 0, 0);
         for (i = 0; i < n; i++) begin
            if (p == 5 && i == 30) hold_req = 1'b1;
            send_word(random_word());
         end
         drain();
      end

      if (mismatches == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[text_console_writer.f]
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_seq.sv
design/text_console_writer.sv
tb/sv/tcw_console_checker.sv
tb/sv/tb_text_console_writer.sv
